// ===== src/sorted_priority_table_defines.svh =====
// Assertion macros shared by the sorted priority table RTL.
`ifndef SORTED_PRIORITY_TABLE_DEFINES_SVH
`define SORTED_PRIORITY_TABLE_DEFINES_SVH
// Asserts an implication property on the rising clock, disabled in reset.
`define SPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Asserts that a condition never holds on the rising clock, disabled in reset.
`define SPT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

// ===== src/spt_pkg.sv =====
// Shared types and constants for the sorted priority table.
package spt_pkg;
    localparam int unsigned DEPTH_DEF = 16;
    localparam logic [4:0] CAP_RESET = 5'd16;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DEL_MAX = 3'd1,
        OP_LIST_MAX = 3'd2,
        OP_CHANGE = 3'd3,
        OP_LIST_ALL = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_FULL = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD_IDX = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT_RD,
        S_SORT_WAIT,
        S_SORT_CMP,
        S_SORT_WB,
        S_MAX_RD,
        S_MAX_WAIT,
        S_SCAN,
        S_DONE
    } t_state;
endpackage

// ===== src/spt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module spt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/sorted_priority_table.sv =====
// Top level of the sorted priority table: sequencer, compare unit and entry memory.
//
// Usage: present an operation on i_op, i_new_key, i_record_handle and i_slot with
// start high while busy is low; that beat is taken at the clock edge. The block
// then runs on its own and drops each result on the o_ ports for one cycle, marked
// by o_res_valid; the receiver cannot stall, so every result is taken as shown.
// o_final_res marks the last result of an operation.
// Insert and change key run an exchange sort on one shared signed comparator: one
// compare per cycle, and each outer pass also passes through a read, a wait and a
// write-back state. busy stays high through the sort and the done state, and the
// result follows in the next cycle.
// Delete max and the list operations read the maximum and scan one entry per cycle;
// busy stays high through the read, wait, scan and done states, and listed entries
// come one per cycle. Full, bad index and empty outcomes go straight to the done state.
// The capacity register is written through i_cfg_valid / o_cfg_ready; ready is low
// while busy. Synchronous reset empties the table and sets capacity to sixteen; the
// entry memories are not cleared since only entries below the fill count are read.
`include "sorted_priority_table_defines.svh"
module sorted_priority_table import spt_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_op,
    input  logic signed [15:0] i_new_key,
    input  logic [31:0] i_record_handle,
    input  logic [3:0]  i_slot,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    output logic        o_res_valid,
    output logic [1:0]  o_status,
    output logic [3:0]  o_entry_pos,
    output logic signed [15:0] o_entry_key,
    output logic [31:0] o_entry_handle,
    output logic [4:0]  o_removed,
    output logic        o_final_res
);
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned FW = $clog2(DEPTH + 1);
    localparam int unsigned LW = (FW > 5) ? FW : 5;

    t_state r_state, n_state;
    logic [4:0] r_cap;
    logic [FW-1:0] r_fill, n_fill;
    logic [2:0] r_op;
    t_status r_pre, pre_st;
    logic [AW-1:0] r_i, n_i, r_j, n_j;
    logic signed [15:0] r_ki, n_ki, r_max, n_max;
    logic [31:0] r_hi, n_hi;
    logic [FW-1:0] r_cnt, n_cnt;

    // Result register.
    logic r_rv, n_rv;
    t_status r_st, n_st;
    logic [3:0] r_pos, n_pos;
    logic signed [15:0] r_ek, n_ek;
    logic [31:0] r_eh, n_eh;
    logic [4:0] r_rm, n_rm;
    logic r_fin, n_fin;

    // Memory ports.
    logic we_key, we_hd;
    logic [AW-1:0] waddr, raddr;
    logic [15:0] wkey, rkey;
    logic [31:0] whd, rhd;

    spt_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_keys (
        .i_clk(i_clk), .i_we(we_key), .i_waddr(waddr), .i_wdata(wkey),
        .i_raddr(raddr), .o_rdata(rkey)
    );
    spt_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_hds (
        .i_clk(i_clk), .i_we(we_hd), .i_waddr(waddr), .i_wdata(whd),
        .i_raddr(raddr), .o_rdata(rhd)
    );

    logic [LW-1:0] limit, fill_x, slot_x;
    logic accept;
    logic signed [15:0] rk_s;
    logic [FW-1:0] j_next, i_next2;
    logic ins_ok, chg_ok, is_empty;

    assign fill_x = LW'(r_fill);
    assign slot_x = LW'(i_slot);
    assign limit = (LW'(r_cap) < LW'(DEPTH)) ? LW'(r_cap) : LW'(DEPTH);
    assign busy = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign o_cfg_ready = !busy;
    assign rk_s = rkey;
    assign j_next = FW'(r_j) + FW'(1);
    assign i_next2 = FW'(r_i) + FW'(2);
    assign ins_ok = fill_x < limit;
    assign chg_ok = slot_x < fill_x;
    assign is_empty = (r_fill == '0);

    // Outcome of the operation that is known at accept.
    always_comb begin
        pre_st = ST_OK;
        unique case (i_op)
            OP_INSERT: if (!ins_ok) pre_st = ST_FULL;
            OP_CHANGE: if (!chg_ok) pre_st = ST_BAD_IDX;
            default: if (is_empty) pre_st = ST_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap <= CAP_RESET;
            r_fill <= '0;
            r_rv <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill <= n_fill;
            r_rv <= n_rv;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_op;
            r_pre <= pre_st;
        end
        r_i <= n_i;
        r_j <= n_j;
        r_ki <= n_ki;
        r_hi <= n_hi;
        r_max <= n_max;
        r_cnt <= n_cnt;
        r_st <= n_st;
        r_pos <= n_pos;
        r_ek <= n_ek;
        r_eh <= n_eh;
        r_rm <= n_rm;
        r_fin <= n_fin;
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_op)
                        OP_INSERT: n_state = (ins_ok && !is_empty) ? S_SORT_RD : S_DONE;
                        OP_CHANGE: n_state = (chg_ok && r_fill != FW'(1))
                                             ? S_SORT_RD : S_DONE;
                        OP_DEL_MAX, OP_LIST_MAX, OP_LIST_ALL:
                            n_state = is_empty ? S_DONE : S_MAX_RD;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SORT_RD: n_state = S_SORT_WAIT;
            S_SORT_WAIT: n_state = S_SORT_CMP;
            S_SORT_CMP: n_state = (j_next < r_fill) ? S_SORT_CMP : S_SORT_WB;
            S_SORT_WB: n_state = (i_next2 < r_fill) ? S_SORT_RD : S_DONE;
            S_MAX_RD: n_state = S_MAX_WAIT;
            S_MAX_WAIT: n_state = S_SCAN;
            S_SCAN: n_state = (j_next < r_fill) ? S_SCAN : S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb begin
        n_fill = r_fill;
        n_i = r_i;
        n_j = r_j;
        n_ki = r_ki;
        n_hi = r_hi;
        n_max = r_max;
        n_cnt = r_cnt;
        we_key = 1'b0;
        we_hd = 1'b0;
        waddr = r_j;
        wkey = r_ki;
        whd = r_hi;
        raddr = r_i;
        n_rv = 1'b0;
        n_st = ST_OK;
        n_pos = '0;
        n_ek = '0;
        n_eh = '0;
        n_rm = '0;
        n_fin = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_i = '0;
                n_cnt = '0;
                if (accept && i_op == OP_INSERT && ins_ok) begin
                    we_key = 1'b1;
                    we_hd = 1'b1;
                    waddr = AW'(r_fill);
                    wkey = i_new_key;
                    whd = i_record_handle;
                    n_fill = r_fill + FW'(1);
                end else if (accept && i_op == OP_CHANGE && chg_ok) begin
                    // Only the key changes; the handle memory is left alone.
                    we_key = 1'b1;
                    waddr = AW'(i_slot);
                    wkey = i_new_key;
                end
            end
            S_SORT_RD: begin
                raddr = r_i;
                n_j = r_i + AW'(1);
            end
            S_SORT_WAIT: begin
                n_ki = rk_s;
                n_hi = rhd;
                raddr = r_j;
            end
            S_SORT_CMP: begin
                // The read data holds entry j; r_ki/r_hi hold the current entry i.
                if (r_ki > rk_s) begin
                    we_key = 1'b1;
                    we_hd = 1'b1;
                    waddr = r_j;
                    wkey = r_ki;
                    whd = r_hi;
                    n_ki = rk_s;
                    n_hi = rhd;
                end
                n_j = r_j + AW'(1);
                raddr = r_j + AW'(1);
            end
            S_SORT_WB: begin
                we_key = 1'b1;
                we_hd = 1'b1;
                waddr = r_i;
                wkey = r_ki;
                whd = r_hi;
                n_i = r_i + AW'(1);
            end
            S_MAX_RD: raddr = AW'(r_fill - FW'(1));
            S_MAX_WAIT: begin
                n_max = rk_s;
                n_j = '0;
                raddr = '0;
            end
            S_SCAN: begin
                if (rk_s == r_max) begin
                    n_cnt = r_cnt + FW'(1);
                end
                if (r_op == OP_LIST_ALL || (r_op == OP_LIST_MAX && rk_s == r_max)) begin
                    n_rv = 1'b1;
                    n_pos = 4'(r_j);
                    n_ek = rk_s;
                    n_eh = rhd;
                    // The table is sorted, so the last entry is also the last max entry.
                    n_fin = !(j_next < r_fill);
                end
                n_j = r_j + AW'(1);
                raddr = r_j + AW'(1);
            end
            S_DONE: begin
                if (r_op == OP_INSERT || r_op == OP_CHANGE || r_op == OP_DEL_MAX ||
                    r_pre != ST_OK) begin
                    n_rv = 1'b1;
                    n_fin = 1'b1;
                    n_st = r_pre;
                    if (r_op == OP_DEL_MAX && r_pre == ST_OK) begin
                        n_rm = 5'(r_cnt);
                        n_fill = r_fill - r_cnt;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_res_valid = r_rv;
    assign o_status = r_st;
    assign o_entry_pos = r_pos;
    assign o_entry_key = r_ek;
    assign o_entry_handle = r_eh;
    assign o_removed = r_rm;
    assign o_final_res = r_fin;

    `SPT_ASSERT(a_busy_ins, i_clk, i_rst_n, accept && i_op == OP_INSERT |=> busy, "busy must follow an insert beat")
    `SPT_NEVER(a_fill_cap, i_clk, i_rst_n, LW'(r_fill) > LW'(DEPTH), "fill exceeds depth")
    `SPT_ASSERT(a_err_final, i_clk, i_rst_n, o_res_valid && o_status != ST_OK |-> o_final_res, "error result must be final")
    `SPT_NEVER(a_cfg_busy, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready && busy, "capacity written while busy")
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the sorted priority table, with a scoreboard class.
module tb;
    import spt_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  pos;
        logic [15:0] key;
        logic [31:0] handle;
        logic [4:0]  removed;
        logic        last;
    } t_res;

    class table_scoreboard;
        logic signed [15:0] keys[16];
        logic [31:0] handles[16];
        int unsigned fill;
        int unsigned cap;
        t_res pending[$];
        int unsigned mismatches;

        function void clear();
            fill = 0;
            cap = 16;
            pending.delete();
            mismatches = 0;
        endfunction

        function void resort();
            logic signed [15:0] tk;
            logic [31:0] th;
            for (int i = 0; i + 1 < fill; i++)
                for (int j = i + 1; j < fill; j++)
                    if (keys[i] > keys[j]) begin
                        tk = keys[i]; th = handles[i];
                        keys[i] = keys[j]; handles[i] = handles[j];
                        keys[j] = tk; handles[j] = th;
                    end
        endfunction

        function void push(logic [1:0] st, int unsigned p, logic [15:0] k,
                           logic [31:0] h, int unsigned rm, bit lst);
            t_res r;
            r.status = st; r.pos = p[3:0]; r.key = k; r.handle = h;
            r.removed = rm[4:0]; r.last = lst;
            pending.push_back(r);
        endfunction

        function void note_item(logic [2:0] op, logic signed [15:0] nk,
                                logic [31:0] hd, logic [3:0] sl);
            int unsigned limit, cnt, n, lastpos;
            logic signed [15:0] mx;
            limit = cap < 16 ? cap : 16;
            case (op)
                OP_INSERT: begin
                    if (fill >= limit) push(ST_FULL, 0, 0, 0, 0, 1);
                    else begin
                        keys[fill] = nk; handles[fill] = hd; fill++;
                        resort();
                        push(ST_OK, 0, 0, 0, 0, 1);
                    end
                end
                OP_DEL_MAX, OP_LIST_MAX: begin
                    if (fill == 0) push(ST_EMPTY, 0, 0, 0, 0, 1);
                    else begin
                        mx = keys[fill-1];
                        cnt = 0;
                        for (int i = 0; i < fill; i++)
                            if (keys[i] == mx) begin cnt++; lastpos = i; end
                        if (op == OP_DEL_MAX) begin
                            fill -= cnt;
                            push(ST_OK, 0, 0, 0, cnt, 1);
                        end else begin
                            for (int i = 0; i < fill; i++)
                                if (keys[i] == mx)
                                    push(ST_OK, i, keys[i], handles[i], 0, i == lastpos);
                        end
                    end
                end
                OP_CHANGE: begin
                    if (sl >= fill) push(ST_BAD_IDX, 0, 0, 0, 0, 1);
                    else begin
                        keys[sl] = nk; resort();
                        push(ST_OK, 0, 0, 0, 0, 1);
                    end
                end
                OP_LIST_ALL: begin
                    n = fill;
                    if (n == 0) push(ST_EMPTY, 0, 0, 0, 0, 1);
                    else for (int i = 0; i < n; i++)
                        push(ST_OK, i, keys[i], handles[i], 0, i + 1 == n);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, start, busy;
    logic [2:0] i_op;
    logic signed [15:0] i_new_key;
    logic [31:0] i_record_handle;
    logic [3:0] i_slot;
    logic i_cfg_valid, o_cfg_ready;
    logic [4:0] i_cfg_data;
    logic o_res_valid;
    logic [1:0] o_status;
    logic [3:0] o_entry_pos;
    logic signed [15:0] o_entry_key;
    logic [31:0] o_entry_handle;
    logic [4:0] o_removed;
    logic o_final_res;

    sorted_priority_table dut (.*);

    table_scoreboard sb;
    int unsigned cycles = 0;
    bit timed_out = 1'b0;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_res_valid)
            sb.check_result({o_status, o_entry_pos, o_entry_key, o_entry_handle,
                             o_removed, o_final_res});
        if (cycles > 2000000 && !timed_out) begin
            timed_out = 1;
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_op(logic [2:0] op, logic signed [15:0] nk, logic [31:0] hd,
                           logic [3:0] sl);
        start <= 1; i_op <= op; i_new_key <= nk; i_record_handle <= hd; i_slot <= sl;
        do @(posedge i_clk); while (busy);
        sb.note_item(op, nk, hd, sl);
        start <= 0;
        @(posedge i_clk);
    endtask

    task automatic idle_gap();
        int unsigned g;
        g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 20) : 0;
        repeat (g) @(posedge i_clk);
    endtask

    // Waits out every expected result plus the longest sort, then sets capacity.
    task automatic write_capacity(logic [4:0] v);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        i_cfg_valid <= 1; i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        sb.cap = v;
    endtask

    function automatic logic signed [15:0] pick_key();
        case ($urandom_range(0, 4))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_ops(int unsigned n);
        logic [2:0] op;
        int unsigned burst;
        while (n > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && n > 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: op = OP_INSERT;
                    4: op = OP_DEL_MAX;
                    5: op = OP_LIST_MAX;
                    6, 7: op = OP_CHANGE;
                    8: op = OP_LIST_ALL;
                    default: op = 3'($urandom_range(5, 7));
                endcase
                send_op(op, pick_key(), $urandom, 4'($urandom_range(0, 15)));
                burst--; n--;
            end
            repeat ($urandom_range(0, 15)) @(posedge i_clk);
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        start = 0; i_op = 0; i_new_key = 0; i_record_handle = 0; i_slot = 0;
        i_cfg_valid = 0; i_cfg_data = 0;
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Empty table for every reading operation, a bad slot and two unused op codes, then extreme keys.
        send_op(OP_DEL_MAX, 16'sd0, 32'd0, 4'd0);
        send_op(OP_LIST_MAX, 16'sd0, 32'd0, 4'd0);
        send_op(OP_LIST_ALL, 16'sd0, 32'd0, 4'd0);
        send_op(OP_CHANGE, 16'sd5, 32'd0, 4'd0);
        send_op(3'd5, 16'sd0, 32'd0, 4'd0);
        send_op(3'd7, 16'sd0, 32'd0, 4'd0);
        send_op(OP_INSERT, 16'sh7fff, 32'hffffffff, 4'hf);
        send_op(OP_INSERT, 16'sh8000, 32'h0, 4'd0);
        send_op(OP_INSERT, 16'sh7fff, 32'h12345678, 4'd0);
        send_op(OP_INSERT, -16'sd1, 32'hdeadbeef, 4'd0);
        send_op(OP_LIST_MAX, 16'sd0, 32'd0, 4'd0);
        send_op(OP_CHANGE, 16'sh7fff, 32'd0, 4'd0);
        send_op(OP_CHANGE, 16'sd0, 32'd0, 4'd4);
        send_op(OP_LIST_ALL, 16'sd0, 32'd0, 4'd0);
        send_op(OP_DEL_MAX, 16'sd0, 32'd0, 4'd0);
        send_op(OP_LIST_ALL, 16'sd0, 32'd0, 4'd0);

        // Capacity zero, capacity above the depth, capacity below fill, then full table.
        write_capacity(5'd0);
        send_op(OP_INSERT, 16'sd1, 32'd1, 4'd0);
        send_op(OP_LIST_ALL, 16'sd0, 32'd0, 4'd0);
        write_capacity(5'd31);
        random_ops(60);
        write_capacity(5'd1);
        random_ops(40);
        write_capacity(5'd3);
        random_ops(60);
        write_capacity(5'd16);
        repeat (18) send_op(OP_INSERT, pick_key(), $urandom, 4'd0);
        send_op(OP_LIST_ALL, 16'sd0, 32'd0, 4'd0);
        send_op(OP_CHANGE, 16'sh8000, 32'd0, 4'd15);
        random_ops(120);
        for (int i = 0; i < 20; i++) begin
            send_op(OP_LIST_ALL, 16'sd0, 32'd0, 4'd0);
            idle_gap();
        end

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (sb.mismatches == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
